FILE: rtl/core/lmslr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmslr_pkg
// Shared widths, constants and types for the LMS regression update core.
// ----------------------------------------------------------------------------
package lmslr_pkg;

    localparam int TAPS     = 3;
    localparam int SMP_W    = 16;                  // sample / target, Q3.12
    localparam int WGT_W    = 32;                  // weight, Q7.24
    localparam int STEP_W   = 16;                  // step size, unsigned Q0.16
    localparam int ERR_W    = SMP_W + 1;           // error, Q4.12
    localparam int PROD_W   = WGT_W + SMP_W;       // weight * sample
    localparam int ACC_W    = PROD_W + $clog2(TAPS + 1);
    localparam int SE_W     = 2 * ERR_W;           // step * error
    localparam int DPROD_W  = SE_W + SMP_W;        // step * error * sample
    localparam int PRED_SH  = 24;                  // Q.36 -> Q.12
    localparam int DELTA_SH = 16;                  // Q.40 -> Q.24
    localparam int DELTA_W  = DPROD_W - DELTA_SH;
    localparam int NW_W     = DELTA_W + 1;
    localparam int CNT_W    = $clog2(TAPS + 1);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655);

    // Per-cycle commands from the sequencer to every cell.
    typedef struct packed {
        logic load;     // capture the sample of a new transfer
        logic prod;     // form weight * sample
        logic mul;      // form step * error * sample
        logic upd;      // commit the new weight
    } t_cell_ctrl;

endpackage

FILE: rtl/core/lmslr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmslr_cell
// One tap: holds a weight and its sample, adds its product to the partial
// sum passed along the chain, and applies the delta-rule weight update.
// ----------------------------------------------------------------------------
module lmslr_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lmslr_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [lmslr_pkg::SMP_W-1:0]   i_sample,
    input  logic signed [lmslr_pkg::ACC_W-1:0]   i_psum,
    output logic signed [lmslr_pkg::ACC_W-1:0]   o_psum,
    input  logic signed [lmslr_pkg::SE_W-1:0]    i_se,
    output logic signed [lmslr_pkg::WGT_W-1:0]   o_weight,
    output logic signed [lmslr_pkg::WGT_W-1:0]   o_weight_next
);

    localparam logic signed [lmslr_pkg::NW_W-1:0] WMAX =
        lmslr_pkg::NW_W'({1'b0, {(lmslr_pkg::WGT_W-1){1'b1}}});
    localparam logic signed [lmslr_pkg::NW_W-1:0] WMIN = -WMAX - 1;
    localparam logic signed [lmslr_pkg::DPROD_W-1:0] RND =
        lmslr_pkg::DPROD_W'(1) <<< (lmslr_pkg::DELTA_SH - 1);

    logic signed [lmslr_pkg::WGT_W-1:0]   r_weight;
    logic signed [lmslr_pkg::SMP_W-1:0]   r_sample;
    logic signed [lmslr_pkg::PROD_W-1:0]  r_prod;
    logic signed [lmslr_pkg::ACC_W-1:0]   r_psum;
    logic signed [lmslr_pkg::DPROD_W-1:0] r_dprod;

    logic signed [lmslr_pkg::DPROD_W-1:0] s_rnd;
    logic signed [lmslr_pkg::DELTA_W-1:0] s_delta;
    logic signed [lmslr_pkg::NW_W-1:0]    s_sum;
    logic signed [lmslr_pkg::WGT_W-1:0]   n_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_ctrl.upd) begin
            r_weight <= n_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_sample <= i_sample;
        end
        if (i_ctrl.prod) begin
            r_prod <= lmslr_pkg::PROD_W'(r_weight) * lmslr_pkg::PROD_W'(r_sample);
        end
        if (i_ctrl.mul) begin
            r_dprod <= lmslr_pkg::DPROD_W'(i_se) * lmslr_pkg::DPROD_W'(r_sample);
        end
        // pass the partial sum on every cycle; it settles one cell per cycle
        r_psum <= i_psum + lmslr_pkg::ACC_W'(r_prod);
    end

    always_comb begin
        s_rnd   = r_dprod + RND;
        s_delta = s_rnd[lmslr_pkg::DPROD_W-1:lmslr_pkg::DELTA_SH];
        s_sum   = lmslr_pkg::NW_W'(r_weight) + lmslr_pkg::NW_W'(s_delta);
        if (s_sum > WMAX) begin
            n_weight = WMAX[lmslr_pkg::WGT_W-1:0];
        end else if (s_sum < WMIN) begin
            n_weight = WMIN[lmslr_pkg::WGT_W-1:0];
        end else begin
            n_weight = s_sum[lmslr_pkg::WGT_W-1:0];
        end
    end

    assign o_psum        = r_psum;
    assign o_weight      = r_weight;
    assign o_weight_next = n_weight;

endmodule

FILE: rtl/core/lms_linear_regression_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_linear_regression_update_core
// Online LMS (delta rule) learner: predict, form error, update weights.
// ----------------------------------------------------------------------------
// A new input transfer is taken only in the idle state, so the core works on
// one item at a time; the result register is loaded together with the weight
// commit. A stalled result holds the weight commit, and with it the next
// input transfer, until it is taken.
// The sequence is set by the weight feedback loop through the row of tap
// cells: the samples are captured at the input transfer, then the weight *
// sample products are formed, the partial sum ripples down the chain, the
// prediction is rounded and saturated and the error formed, step * error is
// formed, then the per-tap update product, and the weights are committed,
// followed by a return to idle before the next transfer.
// The prediction uses the weights before the update; weights saturate to
// Q7.24 independently. A finished result sits in an output register, so the
// next input transfer is taken while it waits. Write step_size only while
// the core is idle.
// ----------------------------------------------------------------------------
module lms_linear_regression_update_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lmslr_pkg::STEP_W-1:0]        i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [lmslr_pkg::SMP_W-1:0]  i_sample_0,
    input  logic signed [lmslr_pkg::SMP_W-1:0]  i_sample_1,
    input  logic signed [lmslr_pkg::SMP_W-1:0]  i_sample_2,
    input  logic signed [lmslr_pkg::SMP_W-1:0]  i_target,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [lmslr_pkg::SMP_W-1:0]  o_prediction,
    output logic signed [lmslr_pkg::ERR_W-1:0]  o_error,
    output logic signed [lmslr_pkg::WGT_W-1:0]  o_weight_0_out,
    output logic signed [lmslr_pkg::WGT_W-1:0]  o_weight_1_out,
    output logic signed [lmslr_pkg::WGT_W-1:0]  o_weight_2_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PROD = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_ERR  = 3'd3;
    localparam logic [2:0] ST_SE   = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_UPD  = 3'd6;

    localparam int PRED_W = lmslr_pkg::ACC_W - lmslr_pkg::PRED_SH;
    localparam logic signed [PRED_W-1:0] PMAX =
        PRED_W'({1'b0, {(lmslr_pkg::SMP_W-1){1'b1}}});
    localparam logic signed [PRED_W-1:0] PMIN = -PMAX - 1;
    localparam logic signed [lmslr_pkg::ACC_W-1:0] PRND =
        lmslr_pkg::ACC_W'(1) <<< (lmslr_pkg::PRED_SH - 1);
    localparam logic [lmslr_pkg::CNT_W-1:0] SUM_LAST =
        lmslr_pkg::CNT_W'(lmslr_pkg::TAPS - 1);

    // control
    logic [2:0]                        r_state, n_state;
    logic [lmslr_pkg::CNT_W-1:0]       r_cnt;
    logic [lmslr_pkg::STEP_W-1:0]      r_step_size;
    logic                              r_o_valid;

    // datapath
    logic signed [lmslr_pkg::SMP_W-1:0] r_target;
    logic signed [lmslr_pkg::SMP_W-1:0] r_pred;
    logic signed [lmslr_pkg::ERR_W-1:0] r_err;
    logic signed [lmslr_pkg::SE_W-1:0]  r_se;
    logic signed [lmslr_pkg::SMP_W-1:0] r_o_pred;
    logic signed [lmslr_pkg::ERR_W-1:0] r_o_err;
    logic signed [lmslr_pkg::WGT_W-1:0] r_o_w [lmslr_pkg::TAPS];

    logic                               s_accept;
    logic                               s_out_free;
    lmslr_pkg::t_cell_ctrl              s_ctrl;
    logic signed [lmslr_pkg::SMP_W-1:0] s_sample  [lmslr_pkg::TAPS];
    logic signed [lmslr_pkg::ACC_W-1:0] s_psum    [lmslr_pkg::TAPS+1];
    logic signed [lmslr_pkg::WGT_W-1:0] s_weight  [lmslr_pkg::TAPS];
    logic signed [lmslr_pkg::WGT_W-1:0] s_wnext   [lmslr_pkg::TAPS];
    logic signed [lmslr_pkg::ACC_W-1:0] s_rnd;
    logic signed [PRED_W-1:0]           s_shr;
    logic signed [lmslr_pkg::SMP_W-1:0] s_pred;

    assign s_sample[0] = i_sample_0;
    assign s_sample[1] = i_sample_1;
    assign s_sample[2] = i_sample_2;
    assign s_psum[0]   = '0;

    assign o_in_ready = (r_state == ST_IDLE);
    assign s_accept   = i_in_valid && o_in_ready;
    // the output slot is free if empty or drained at this edge
    assign s_out_free = !r_o_valid || i_out_ready;

    always_comb begin
        s_ctrl.load = s_accept;
        s_ctrl.prod = (r_state == ST_PROD);
        s_ctrl.mul  = (r_state == ST_MUL);
        s_ctrl.upd  = (r_state == ST_UPD) && s_out_free;
    end

    // ---- row of tap cells; partial sum flows from cell 0 to the last cell
    for (genvar g = 0; g < lmslr_pkg::TAPS; g++) begin : g_cell
        lmslr_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (s_ctrl),
            .i_sample      (s_sample[g]),
            .i_psum        (s_psum[g]),
            .o_psum        (s_psum[g+1]),
            .i_se          (r_se),
            .o_weight      (s_weight[g]),
            .o_weight_next (s_wnext[g])
        );
    end

    // ---- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_accept) n_state = ST_PROD;
            ST_PROD: n_state = ST_SUM;
            ST_SUM:  if (r_cnt == SUM_LAST) n_state = ST_ERR;
            ST_ERR:  n_state = ST_SE;
            ST_SE:   n_state = ST_MUL;
            ST_MUL:  n_state = ST_UPD;
            ST_UPD:  if (s_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_step_size <= lmslr_pkg::STEP_RESET;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            // count ripple cycles of the partial sum chain
            if (r_state == ST_SUM) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (i_cfg_we) begin
                r_step_size <= i_cfg_wdata;
            end
            if (s_ctrl.upd) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ---- prediction: round half up from Q.36, saturate to Q3.12
    always_comb begin
        s_rnd = s_psum[lmslr_pkg::TAPS] + PRND;
        s_shr = s_rnd[lmslr_pkg::ACC_W-1:lmslr_pkg::PRED_SH];
        if (s_shr > PMAX) begin
            s_pred = PMAX[lmslr_pkg::SMP_W-1:0];
        end else if (s_shr < PMIN) begin
            s_pred = PMIN[lmslr_pkg::SMP_W-1:0];
        end else begin
            s_pred = s_shr[lmslr_pkg::SMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_target <= i_target;
        end
        if (r_state == ST_ERR) begin
            r_pred <= s_pred;
            r_err  <= lmslr_pkg::ERR_W'(r_target) - lmslr_pkg::ERR_W'(s_pred);
        end
        if (r_state == ST_SE) begin
            r_se <= lmslr_pkg::SE_W'($signed({1'b0, r_step_size}))
                    * lmslr_pkg::SE_W'(r_err);
        end
        // hold the result until the transfer on the output side
        if (s_ctrl.upd) begin
            r_o_pred <= r_pred;
            r_o_err  <= r_err;
            for (int k = 0; k < lmslr_pkg::TAPS; k++) begin
                r_o_w[k] <= s_wnext[k];
            end
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_prediction   = r_o_pred;
    assign o_error        = r_o_err;
    assign o_weight_0_out = r_o_w[0];
    assign o_weight_1_out = r_o_w[1];
    assign o_weight_2_out = r_o_w[2];

    // ---- assertions
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_PROD))
        else $error("accepted transfer did not start the update sequence");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_UPD))
        else $error("result appeared outside the weight commit step");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_error) && $stable(o_prediction)))
        else $error("waiting result changed before its transfer");

    a_weight_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(s_ctrl.upd)) |->
            ($stable(s_weight[0]) && $stable(s_weight[lmslr_pkg::TAPS-1])))
        else $error("weight changed outside the commit step");

endmodule
